>>> rtl/core/tlec_pkg.sv
package tlec_pkg;

	localparam int ADDR_W     = 32;
	localparam int STAT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} access_t;

	typedef struct packed {
		logic [STAT_W-1:0] l1_status;
		logic [STAT_W-1:0] l2_status;
	} result_t;

	localparam logic [STAT_W-1:0] STAT_NONE    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_RD_HIT  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RD_MISS = 3'd2;
	localparam logic [STAT_W-1:0] STAT_WR_HIT  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_WR_MISS = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_L1_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS   = 3'd5;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_L1_ROW,
		ST_L1_RD,
		ST_L1_CMP,
		ST_VIC_RD,
		ST_VIC,
		ST_L2V_ROW,
		ST_L2V_PLACE,
		ST_L2_ROW,
		ST_L2_RD,
		ST_L2_CMP
	} state_t;

endpackage

>>> rtl/core/two_level_exclusive_cache_tags_top.sv
// An L1 lookup reads the set's row, then reads and compares one tag per way in order up to a hit
// or the last configured way; an L1 miss then reads the L2 row and searches the L2 ways alike,
// and a read miss that evicts first moves the L1 victim block into its L2 set.
// One shared tag comparator scans the ways one at a time; a new start is taken while done
// is high. After reset the block stays busy while it clears the valid bits and round-robin
// pointers of every set of both levels, one set per cycle.
module two_level_exclusive_cache_tags_top #(
	parameter int L1_SETS = 64,
	parameter int L1_WAYS = 8,
	parameter int L2_SETS = 512,
	parameter int L2_WAYS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tlec_pkg::access_t                   access,
	output logic                                done,
	output tlec_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [tlec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tlec_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import tlec_pkg::*;

	localparam int L1_SW      = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
	localparam int L2_SW      = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
	localparam int L1_IDX_MAX = $clog2(L1_SETS + 1) - 1;
	localparam int L2_IDX_MAX = $clog2(L2_SETS + 1) - 1;
	localparam int L1_WIW     = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
	localparam int L2_WIW     = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
	localparam int L1_WCW     = $clog2(L1_WAYS + 1);
	localparam int L2_WCW     = $clog2(L2_WAYS + 1);
	localparam int CW         = (L1_WCW > L2_WCW) ? L1_WCW : L2_WCW;
	localparam int WAY_W      = (L1_WIW > L2_WIW) ? L1_WIW : L2_WIW;
	localparam int L1_RW      = L1_WIW + L1_WAYS;
	localparam int L2_RW      = L2_WIW + L2_WAYS;
	localparam int CLR_N      = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int CLR_W      = (CLR_N > 1) ? $clog2(CLR_N) : 1;

	function automatic logic [31:0] f_tag(logic [31:0] a, logic [3:0] off, logic [3:0] idx);
		return a >> (5'(off) + 5'(idx));
	endfunction

	function automatic logic [31:0] f_set(logic [31:0] a, logic [3:0] off, logic [3:0] idx);
		return (a >> off) & ((32'd1 << idx) - 32'd1);
	endfunction

	// Configuration registers.
	logic [3:0] cfg_l1_off_q, cfg_l1_ways_q, cfg_l2_off_q, cfg_l2_idx_q;
	logic [2:0] cfg_l1_idx_q;
	logic [4:0] cfg_l2_ways_q;

	state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q, clr_d;
	logic done_q, done_d;
	result_t result_q, result_d;

	// Per-item registers.
	logic              wr_q;
	logic [3:0]        o1_q, o2_q, i2_q;
	logic [2:0]        i1_q;
	logic [L1_WCW-1:0] w1_q;
	logic [L2_WCW-1:0] w2_q;
	logic [L1_SW-1:0]  s1_q;
	logic [L2_SW-1:0]  s2_q, vs2_q;
	logic [31:0]       t1_q, t2_q, vt2_q, vaddr_q;
	logic [WAY_W-1:0]  way_q, way_d;
	logic [STAT_W-1:0] l1_stat_q, l1_stat_d;

	// Memories and their read registers.
	logic [31:0]      l1_tag_mem [L1_SETS][L1_WAYS];
	logic [31:0]      l2_tag_mem [L2_SETS][L2_WAYS];
	logic [L1_RW-1:0] l1_row_mem [L1_SETS];
	logic [L2_RW-1:0] l2_row_mem [L2_SETS];
	logic [31:0]      tag1_rd_q, tag2_rd_q;
	logic [L1_RW-1:0] l1_row_rd_q;
	logic [L2_RW-1:0] l2_row_rd_q;

	logic              t1_we, t1_re, t2_we, t2_re, r1_we, r1_re, r2_we, r2_re;
	logic [L1_WIW-1:0] t1_way;
	logic [L2_WIW-1:0] t2_way;
	logic [L1_SW-1:0]  r1_wa;
	logic [L2_SW-1:0]  r2_wa, r2_ra;
	logic [L1_RW-1:0]  r1_wd;
	logic [L2_RW-1:0]  r2_wd;

	logic              accept;
	logic [2:0]        i1_e;
	logic [3:0]        i2_e;
	logic [L1_WCW-1:0] w1_e;
	logic [L2_WCW-1:0] w2_e;
	logic [31:0]       s1_c, t1_c, s2_c, t2_c, vs2_c, vt2_c, vaddr_c;

	logic [L1_WAYS-1:0] v1;
	logic [L1_WIW-1:0]  p1, f1, vw1, np1;
	logic               free1;
	logic [L2_WAYS-1:0] v2;
	logic [L2_WIW-1:0]  p2, f2, vw2, np2;
	logic               free2;

	logic        in_l2;
	logic [31:0] cmp_tag, cmp_key;
	logic        cmp_vld, cmp_hit, cmp_last;
	logic [CW-1:0] cmp_ways;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		i1_e = (int'(cfg_l1_idx_q) > L1_IDX_MAX) ? 3'(L1_IDX_MAX) : cfg_l1_idx_q;
		i2_e = (int'(cfg_l2_idx_q) > L2_IDX_MAX) ? 4'(L2_IDX_MAX) : cfg_l2_idx_q;
		if (cfg_l1_ways_q == '0) begin
			w1_e = L1_WCW'(1);
		end else if (int'(cfg_l1_ways_q) > L1_WAYS) begin
			w1_e = L1_WCW'(L1_WAYS);
		end else begin
			w1_e = L1_WCW'(cfg_l1_ways_q);
		end
		if (cfg_l2_ways_q == '0) begin
			w2_e = L2_WCW'(1);
		end else if (int'(cfg_l2_ways_q) > L2_WAYS) begin
			w2_e = L2_WCW'(L2_WAYS);
		end else begin
			w2_e = L2_WCW'(cfg_l2_ways_q);
		end
		s1_c    = f_set(access.address, cfg_l1_off_q, {1'b0, i1_e});
		t1_c    = f_tag(access.address, cfg_l1_off_q, {1'b0, i1_e});
		s2_c    = f_set(access.address, cfg_l2_off_q, i2_e);
		t2_c    = f_tag(access.address, cfg_l2_off_q, i2_e);
		vs2_c   = f_set(vaddr_q, o2_q, i2_q);
		vt2_c   = f_tag(vaddr_q, o2_q, i2_q);
		vaddr_c = (tag1_rd_q << (5'(o1_q) + 5'(i1_q))) | (32'(s1_q) << o1_q);
	end

	// Row state: first free way and round-robin victim for each level.
	always_comb begin
		v1    = l1_row_rd_q[L1_WAYS-1:0];
		p1    = l1_row_rd_q[L1_RW-1 -: L1_WIW];
		f1    = '0;
		free1 = 1'b0;
		for (int i = L1_WAYS - 1; i >= 0; i--) begin
			if (!v1[i] && (L1_WCW'(i) < w1_q)) begin
				f1    = L1_WIW'(i);
				free1 = 1'b1;
			end
		end
		vw1 = (L1_WCW'(p1) < w1_q) ? p1 : '0;
		np1 = ((L1_WCW'(vw1) + L1_WCW'(1)) >= w1_q) ? '0 : vw1 + L1_WIW'(1);

		v2    = l2_row_rd_q[L2_WAYS-1:0];
		p2    = l2_row_rd_q[L2_RW-1 -: L2_WIW];
		f2    = '0;
		free2 = 1'b0;
		for (int i = L2_WAYS - 1; i >= 0; i--) begin
			if (!v2[i] && (L2_WCW'(i) < w2_q)) begin
				f2    = L2_WIW'(i);
				free2 = 1'b1;
			end
		end
		vw2 = (L2_WCW'(p2) < w2_q) ? p2 : '0;
		np2 = ((L2_WCW'(vw2) + L2_WCW'(1)) >= w2_q) ? '0 : vw2 + L2_WIW'(1);
	end

	// Shared tag comparator for both levels.
	always_comb begin
		in_l2    = (state_q == ST_L2_CMP);
		cmp_tag  = in_l2 ? tag2_rd_q : tag1_rd_q;
		cmp_key  = in_l2 ? t2_q : t1_q;
		cmp_vld  = in_l2 ? v2[way_q[L2_WIW-1:0]] : v1[way_q[L1_WIW-1:0]];
		cmp_ways = in_l2 ? CW'(w2_q) : CW'(w1_q);
		cmp_hit  = cmp_vld && (cmp_tag == cmp_key);
		cmp_last = (CW'(way_q) + CW'(1)) >= cmp_ways;
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		done_d    = 1'b0;
		result_d  = result_q;
		way_d     = way_q;
		l1_stat_d = l1_stat_q;
		t1_we     = 1'b0;
		t1_re     = 1'b0;
		t1_way    = way_q[L1_WIW-1:0];
		t2_we     = 1'b0;
		t2_re     = 1'b0;
		t2_way    = way_q[L2_WIW-1:0];
		r1_we     = 1'b0;
		r1_re     = 1'b0;
		r1_wa     = s1_q;
		r1_wd     = l1_row_rd_q;
		r2_we     = 1'b0;
		r2_re     = 1'b0;
		r2_wa     = s2_q;
		r2_ra     = s2_q;
		r2_wd     = l2_row_rd_q;
		case (state_q)
			ST_CLR: begin
				r1_we = (int'(clr_q) < L1_SETS);
				r1_wa = clr_q[L1_SW-1:0];
				r1_wd = '0;
				r2_we = (int'(clr_q) < L2_SETS);
				r2_wa = clr_q[L2_SW-1:0];
				r2_wd = '0;
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + CLR_W'(1);
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_L1_ROW;
				end
			end
			ST_L1_ROW: begin
				r1_re   = 1'b1;
				way_d   = '0;
				state_d = ST_L1_RD;
			end
			ST_L1_RD: begin
				t1_re   = 1'b1;
				state_d = ST_L1_CMP;
			end
			ST_L1_CMP: begin
				if (cmp_hit) begin
					done_d             = 1'b1;
					result_d.l1_status = wr_q ? STAT_WR_HIT : STAT_RD_HIT;
					result_d.l2_status = STAT_NONE;
					state_d            = ST_IDLE;
				end else if (!cmp_last) begin
					way_d   = way_q + WAY_W'(1);
					state_d = ST_L1_RD;
				end else if (wr_q) begin
					l1_stat_d = STAT_WR_MISS;
					state_d   = ST_L2_ROW;
				end else begin
					l1_stat_d = STAT_RD_MISS;
					if (free1) begin
						t1_we   = 1'b1;
						t1_way  = f1;
						r1_we   = 1'b1;
						r1_wd   = {p1, v1 | (L1_WAYS'(1) << f1)};
						state_d = ST_L2_ROW;
					end else begin
						way_d   = WAY_W'(vw1);
						state_d = ST_VIC_RD;
					end
				end
			end
			ST_VIC_RD: begin
				t1_re   = 1'b1;
				state_d = ST_VIC;
			end
			ST_VIC: begin
				t1_we   = 1'b1;
				r1_we   = 1'b1;
				r1_wd   = {np1, v1 | (L1_WAYS'(1) << way_q[L1_WIW-1:0])};
				state_d = ST_L2V_ROW;
			end
			ST_L2V_ROW: begin
				r2_re   = 1'b1;
				r2_ra   = vs2_c[L2_SW-1:0];
				state_d = ST_L2V_PLACE;
			end
			ST_L2V_PLACE: begin
				t2_we = 1'b1;
				r2_we = 1'b1;
				r2_wa = vs2_q;
				if (free2) begin
					t2_way = f2;
					r2_wd  = {p2, v2 | (L2_WAYS'(1) << f2)};
				end else begin
					t2_way = vw2;
					r2_wd  = {np2, v2 | (L2_WAYS'(1) << vw2)};
				end
				state_d = ST_L2_ROW;
			end
			ST_L2_ROW: begin
				r2_re   = 1'b1;
				way_d   = '0;
				state_d = ST_L2_RD;
			end
			ST_L2_RD: begin
				t2_re   = 1'b1;
				state_d = ST_L2_CMP;
			end
			ST_L2_CMP: begin
				if (cmp_hit) begin
					done_d             = 1'b1;
					result_d.l1_status = l1_stat_q;
					if (wr_q) begin
						result_d.l2_status = STAT_WR_HIT;
					end else begin
						result_d.l2_status = STAT_RD_HIT;
						r2_we = 1'b1;
						r2_wd = {p2, v2 & ~(L2_WAYS'(1) << way_q[L2_WIW-1:0])};
					end
					state_d = ST_IDLE;
				end else if (!cmp_last) begin
					way_d   = way_q + WAY_W'(1);
					state_d = ST_L2_RD;
				end else begin
					done_d             = 1'b1;
					result_d.l1_status = l1_stat_q;
					result_d.l2_status = wr_q ? STAT_WR_MISS : STAT_RD_MISS;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_l1_off_q  <= 4'd6;
			cfg_l1_idx_q  <= 3'd6;
			cfg_l1_ways_q <= 4'd8;
			cfg_l2_off_q  <= 4'd6;
			cfg_l2_idx_q  <= 4'd9;
			cfg_l2_ways_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_L1_OFFSET: cfg_l1_off_q  <= cfg_data[3:0];
				CFG_L1_INDEX:  cfg_l1_idx_q  <= cfg_data[2:0];
				CFG_L1_WAYS:   cfg_l1_ways_q <= cfg_data[3:0];
				CFG_L2_OFFSET: cfg_l2_off_q  <= cfg_data[3:0];
				CFG_L2_INDEX:  cfg_l2_idx_q  <= cfg_data[3:0];
				CFG_L2_WAYS:   cfg_l2_ways_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_q <= access.mode;
			o1_q <= cfg_l1_off_q;
			i1_q <= i1_e;
			w1_q <= w1_e;
			o2_q <= cfg_l2_off_q;
			i2_q <= i2_e;
			w2_q <= w2_e;
			s1_q <= s1_c[L1_SW-1:0];
			t1_q <= t1_c;
			s2_q <= s2_c[L2_SW-1:0];
			t2_q <= t2_c;
		end
		if (state_q == ST_VIC) begin
			vaddr_q <= vaddr_c;
		end
		if (state_q == ST_L2V_ROW) begin
			vs2_q <= vs2_c[L2_SW-1:0];
			vt2_q <= vt2_c;
		end
		way_q     <= way_d;
		l1_stat_q <= l1_stat_d;
		result_q  <= result_d;
	end

	always_ff @(posedge clk) begin
		if (t1_we) begin
			l1_tag_mem[s1_q][t1_way] <= t1_q;
		end
		if (t1_re) begin
			tag1_rd_q <= l1_tag_mem[s1_q][t1_way];
		end
	end

	always_ff @(posedge clk) begin
		if (t2_we) begin
			l2_tag_mem[vs2_q][t2_way] <= vt2_q;
		end
		if (t2_re) begin
			tag2_rd_q <= l2_tag_mem[s2_q][t2_way];
		end
	end

	always_ff @(posedge clk) begin
		if (r1_we) begin
			l1_row_mem[r1_wa] <= r1_wd;
		end
		if (r1_re) begin
			l1_row_rd_q <= l1_row_mem[s1_q];
		end
	end

	always_ff @(posedge clk) begin
		if (r2_we) begin
			l2_row_mem[r2_wa] <= r2_wd;
		end
		if (r2_re) begin
			l2_row_rd_q <= l2_row_mem[r2_ra];
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted transfer did not start the sequencer.");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result strobe without an item in progress.");

	a_l1_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.l1_status == STAT_RD_HIT || result.l1_status == STAT_RD_MISS ||
			result.l1_status == STAT_WR_HIT || result.l1_status == STAT_WR_MISS))
		else $error("L1 status is not a lookup outcome.");

	a_l2_none: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.l2_status == STAT_NONE) |->
			(result.l1_status == STAT_RD_HIT || result.l1_status == STAT_WR_HIT))
		else $error("L2 skipped although L1 missed.");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import tlec_pkg::*;

	localparam int L1_SETS = 64;
	localparam int L1_WAYS = 8;
	localparam int L2_SETS = 512;
	localparam int L2_WAYS = 16;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam int ITEMS_PER_SETTING = 120;
	localparam int DRAIN_CYCLES      = 60;

	typedef struct {
		int unsigned l1_off;
		int unsigned l1_idx;
		int unsigned l1_ways;
		int unsigned l2_off;
		int unsigned l2_idx;
		int unsigned l2_ways;
	} cache_setting_t;

	class cache_status_scoreboard;
		bit          l1_valid [L1_SETS][L1_WAYS];
		logic [31:0] l1_tag   [L1_SETS][L1_WAYS];
		logic [3:0]  l1_rr    [L1_SETS];
		bit          l2_valid [L2_SETS][L2_WAYS];
		logic [31:0] l2_tag   [L2_SETS][L2_WAYS];
		logic [4:0]  l2_rr    [L2_SETS];

		logic [3:0] l1_off;
		logic [2:0] l1_idx;
		logic [3:0] l1_ways;
		logic [3:0] l2_off;
		logic [3:0] l2_idx;
		logic [4:0] l2_ways;

		result_t     pending_status[$];
		int unsigned mismatches;

		function new();
			foreach (l1_valid[s, w]) begin
				l1_valid[s][w] = 1'b0;
				l1_tag[s][w]   = '0;
			end
			foreach (l2_valid[s, w]) begin
				l2_valid[s][w] = 1'b0;
				l2_tag[s][w]   = '0;
			end
			foreach (l1_rr[s]) l1_rr[s] = '0;
			foreach (l2_rr[s]) l2_rr[s] = '0;
			l1_off     = 4'd6;
			l1_idx     = 3'd6;
			l1_ways    = 4'd8;
			l2_off     = 4'd6;
			l2_idx     = 4'd9;
			l2_ways    = 5'd16;
			mismatches = 0;
		endfunction

		function int unsigned fit_bits(int unsigned bits, int unsigned sets);
			while (bits > 0 && (1 << bits) > sets)
				bits--;
			return bits;
		endfunction

		function int unsigned fit_ways(int unsigned ways, int unsigned limit);
			if (ways == 0)
				return 1;
			return (ways > limit) ? limit : ways;
		endfunction

		function int l2_find(logic [31:0] row, logic [31:0] tag, int unsigned ways);
			for (int i = 0; i < ways; i++) begin
				if (l2_valid[row][i] && l2_tag[row][i] == tag)
					return i;
			end
			return -1;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_L1_OFFSET: l1_off  = data[3:0];
				CFG_L1_INDEX:  l1_idx  = data[2:0];
				CFG_L1_WAYS:   l1_ways = data[3:0];
				CFG_L2_OFFSET: l2_off  = data[3:0];
				CFG_L2_INDEX:  l2_idx  = data[3:0];
				CFG_L2_WAYS:   l2_ways = data[4:0];
				default: ;
			endcase
		endfunction

		function void note_access(access_t acc);
			logic [31:0] addr, t1, s1, t2, s2, vtag, vaddr, vt2, vs2;
			logic [63:0] wide;
			int unsigned o1, i1, w1, o2, i2, w2, w;
			int          hit1, hit2, slot;
			result_t     want;
			addr = acc.address;
			o1   = l1_off;
			i1   = fit_bits(l1_idx, L1_SETS);
			w1   = fit_ways(l1_ways, L1_WAYS);
			o2   = l2_off;
			i2   = fit_bits(l2_idx, L2_SETS);
			w2   = fit_ways(l2_ways, L2_WAYS);
			s1   = (addr >> o1) & ((32'd1 << i1) - 32'd1);
			t1   = addr >> (o1 + i1);
			s2   = (addr >> o2) & ((32'd1 << i2) - 32'd1);
			t2   = addr >> (o2 + i2);
			hit1 = -1;
			for (int i = 0; i < w1; i++) begin
				if (hit1 < 0 && l1_valid[s1][i] && l1_tag[s1][i] == t1)
					hit1 = i;
			end
			if (hit1 >= 0) begin
				want.l1_status = (acc.mode == MODE_WRITE) ? STAT_WR_HIT : STAT_RD_HIT;
				want.l2_status = STAT_NONE;
			end else if (acc.mode == MODE_WRITE) begin
				want.l1_status = STAT_WR_MISS;
				want.l2_status = (l2_find(s2, t2, w2) >= 0) ? STAT_WR_HIT : STAT_WR_MISS;
			end else begin
				want.l1_status = STAT_RD_MISS;
				slot = -1;
				for (int i = 0; i < w1; i++) begin
					if (slot < 0 && !l1_valid[s1][i])
						slot = i;
				end
				if (slot >= 0) begin
					l1_valid[s1][slot] = 1'b1;
					l1_tag[s1][slot]   = t1;
				end else begin
					// The set is full: evict the round-robin way and move its block to L2.
					w = (l1_rr[s1] < w1) ? l1_rr[s1] : 0;
					vtag = l1_tag[s1][w];
					l1_tag[s1][w]   = t1;
					l1_valid[s1][w] = 1'b1;
					l1_rr[s1] = 4'((w + 1 >= w1) ? 0 : w + 1);
					wide  = ({32'd0, vtag} << (o1 + i1)) | ({32'd0, s1} << o1);
					vaddr = wide[31:0];
					vs2   = (vaddr >> o2) & ((32'd1 << i2) - 32'd1);
					vt2   = vaddr >> (o2 + i2);
					slot  = -1;
					for (int i = 0; i < w2; i++) begin
						if (slot < 0 && !l2_valid[vs2][i])
							slot = i;
					end
					if (slot < 0) begin
						slot = (l2_rr[vs2] < w2) ? l2_rr[vs2] : 0;
						l2_rr[vs2] = 5'((slot + 1 >= w2) ? 0 : slot + 1);
					end
					l2_valid[vs2][slot] = 1'b1;
					l2_tag[vs2][slot]   = vt2;
				end
				hit2 = l2_find(s2, t2, w2);
				if (hit2 >= 0) begin
					l2_valid[s2][hit2] = 1'b0;
					want.l2_status = STAT_RD_HIT;
				end else begin
					want.l2_status = STAT_RD_MISS;
				end
			end
			pending_status.push_back(want);
		endfunction

		function void check_status(result_t got);
			result_t want;
			if (pending_status.size() == 0) begin
				mismatches++;
				$display("%0t: result with no access outstanding: l1_status %0d l2_status %0d",
					$time, got.l1_status, got.l2_status);
				return;
			end
			want = pending_status.pop_front();
			if (got.l1_status !== want.l1_status) begin
				mismatches++;
				$display("%0t: l1_status expected %0d actual %0d",
					$time, want.l1_status, got.l1_status);
			end
			if (got.l2_status !== want.l2_status) begin
				mismatches++;
				$display("%0t: l2_status expected %0d actual %0d",
					$time, want.l2_status, got.l2_status);
			end
		endfunction

		function int pending();
			return pending_status.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	access_t               access;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cache_status_scoreboard sb = new();

	two_level_exclusive_cache_tags_top #(
		.L1_SETS(L1_SETS),
		.L1_WAYS(L1_WAYS),
		.L2_SETS(L2_SETS),
		.L2_WAYS(L2_WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.access(access),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_status(result);
	end

	task automatic send(logic mode, logic [31:0] addr);
		access_t acc;
		acc.mode    = mode;
		acc.address = addr;
		start  <= 1'b1;
		access <= acc;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_access(acc);
	endtask

	task automatic pause(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		while (sb.pending() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	// Bits above the register width are filled at random; the block must drop them.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value, int unsigned width);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'(value | ($urandom << width));
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
	endtask

	task automatic apply_setting(cache_setting_t s);
		write_reg(CFG_L1_OFFSET, s.l1_off, 4);
		write_reg(CFG_L1_INDEX, s.l1_idx, 3);
		write_reg(CFG_L1_WAYS, s.l1_ways, 4);
		write_reg(CFG_L2_OFFSET, s.l2_off, 4);
		write_reg(CFG_L2_INDEX, s.l2_idx, 4);
		write_reg(CFG_L2_WAYS, s.l2_ways, 5);
		write_reg(CFG_SPARE, $urandom_range(0, 31), 5);
		cfg_we <= 1'b0;
	endtask

	initial begin
		cache_setting_t settings[8];
		logic [31:0]    pool[48];
		logic [31:0]    base, addr;
		int unsigned    shift, idle_pct, i1c;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		access    <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send(MODE_READ, 32'h0000_0000);
		send(MODE_READ, 32'h0000_0000);
		send(MODE_WRITE, 32'h0000_0000);
		send(MODE_WRITE, 32'hFFFF_FFFF);
		send(MODE_READ, 32'hFFFF_FFFF);
		// Eight more blocks in set 0 fill it and push address 0 out to L2.
		for (int k = 1; k <= 8; k++)
			send(MODE_READ, 32'(k) << 12);
		send(MODE_WRITE, 32'h0000_0000);
		send(MODE_READ, 32'h0000_0000);
		send(MODE_READ, 32'h0000_0000);
		send(MODE_WRITE, 32'h0000_1000);
		send(MODE_READ, 32'h0000_1000);
		send(MODE_READ, 32'h8000_0000);
		send(MODE_WRITE, 32'h7FFF_FFC0);
		wait_quiet();

		settings[0] = '{6, 6, 8, 6, 9, 16};
		settings[1] = '{0, 0, 1, 0, 0, 1};
		settings[2] = '{3, 1, 0, 2, 2, 0};
		settings[3] = '{15, 7, 15, 15, 15, 31};
		settings[4] = '{4, 0, 8, 4, 0, 16};
		settings[5] = '{2, 2, 2, 5, 1, 3};
		settings[6] = '{$urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 15),
			$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31)};
		settings[7] = '{12, 3, 4, 8, 5, 7};

		foreach (settings[p]) begin
			apply_setting(settings[p]);
			idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 72 : 13;
			i1c   = (settings[p].l1_idx > 6) ? 6 : settings[p].l1_idx;
			shift = settings[p].l1_off + i1c;
			base  = $urandom;
			// A small pool of blocks crowding a few sets keeps hits, evictions and
			// L2 traffic frequent.
			foreach (pool[j])
				pool[j] = base ^ (32'($urandom_range(0, 15)) << shift)
					^ (32'($urandom_range(0, 3)) << settings[p].l1_off);
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
					pause($urandom_range(1, 8));
				if ($urandom_range(1, 100) <= 85)
					addr = pool[$urandom_range(0, 47)]
						^ ($urandom & ((32'd1 << settings[p].l1_off) - 32'd1));
				else
					addr = $urandom;
				send(($urandom_range(0, 99) < 35) ? MODE_WRITE : MODE_READ, addr);
			end
			wait_quiet();
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
